/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock outside reset
`define DLFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DLFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dlfd_pkg.sv */
// types and constants of the delimited length frame deframer
`timescale 1ns / 1ps
`default_nettype none

package dlfd_pkg;

    localparam int          LEN_BITS_DEF = 16;
    localparam logic [3:0]  HEADER_BYTES = 4'd11;
    localparam logic [3:0]  TYPE_END     = 4'd3;
    localparam logic [3:0]  LEN_OFFSET   = 4'd7;
    localparam logic [7:0]  START_MARK   = 8'h24;
    localparam logic [7:0]  END_MARK     = 8'h23;
    localparam logic [15:0] MAX_BODY_RST = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DELIM    = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] frame_type;
        logic [31:0] source_addr;
        logic [15:0] body_length;
        logic [7:0]  body_byte;
        logic        last;
        t_status     status;
    } t_item;

endpackage

`default_nettype wire

/* rtl/dlfd_core.sv */
// frame parser: header collection, body count and trailer check
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dlfd_core #(
    parameter int LEN_BITS = dlfd_pkg::LEN_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_byte,
    input  wire logic [15:0]    i_max_body,
    output logic                o_item_vld,
    output dlfd_pkg::t_item     o_item
);

    localparam int          CNT_W = (LEN_BITS < 16) ? LEN_BITS : 16;
    localparam logic [32:0] CAP   = (33'd1 << LEN_BITS) - 33'd1;

    dlfd_pkg::t_phase   r_phase, n_phase;
    logic [3:0]         r_hdr_cnt, n_hdr_cnt;
    logic               r_start_ok, n_start_ok;
    logic [15:0]        r_type, n_type;
    logic [31:0]        r_addr, n_addr;
    logic [31:0]        r_len, n_len;
    logic [CNT_W-1:0]   r_body_left, n_body_left;

    logic [3:0]         cnt;
    logic [3:0]         cnt_inc;
    logic               too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dlfd_pkg::PH_HEADER;
            r_hdr_cnt   <= '0;
            r_start_ok  <= 1'b0;
            r_type      <= '0;
            r_addr      <= '0;
            r_len       <= '0;
            r_body_left <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_start_ok  <= n_start_ok;
            r_type      <= n_type;
            r_addr      <= n_addr;
            r_len       <= n_len;
            r_body_left <= n_body_left;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_start_ok  = r_start_ok;
        n_type      = r_type;
        n_addr      = r_addr;
        n_len       = r_len;
        n_body_left = r_body_left;
        o_item_vld  = 1'b0;
        o_item.kind      = dlfd_pkg::KIND_HEADER;
        o_item.body_byte = '0;
        o_item.last      = 1'b0;
        o_item.status    = dlfd_pkg::ST_OK;
        cnt      = (r_hdr_cnt >= dlfd_pkg::HEADER_BYTES) ? 4'd0 : r_hdr_cnt;
        cnt_inc  = cnt + 4'd1;
        too_long = 1'b0;

        if (i_take) begin
            unique case (r_phase)
                dlfd_pkg::PH_BODY: begin
                    o_item_vld       = 1'b1;
                    o_item.kind      = dlfd_pkg::KIND_BODY;
                    o_item.body_byte = i_byte;
                    n_body_left      = r_body_left - {{(CNT_W-1){1'b0}}, 1'b1};
                    if (n_body_left == '0) begin
                        n_phase = dlfd_pkg::PH_TRAILER;
                    end
                end
                dlfd_pkg::PH_TRAILER: begin
                    o_item_vld    = 1'b1;
                    o_item.kind   = dlfd_pkg::KIND_END;
                    o_item.last   = 1'b1;
                    o_item.status = (r_start_ok && i_byte == dlfd_pkg::END_MARK)
                                    ? dlfd_pkg::ST_OK : dlfd_pkg::ST_DELIM;
                    n_phase       = dlfd_pkg::PH_HEADER;
                    n_hdr_cnt     = '0;
                end
                default: begin
                    n_phase = dlfd_pkg::PH_HEADER;
                    if (cnt == 4'd0) begin
                        n_start_ok = (i_byte == dlfd_pkg::START_MARK);
                        n_type     = '0;
                        n_addr     = '0;
                        n_len      = '0;
                    end else if (cnt < dlfd_pkg::TYPE_END) begin
                        n_type = {r_type[7:0], i_byte};
                    end else if (cnt < dlfd_pkg::LEN_OFFSET) begin
                        n_addr = {r_addr[23:0], i_byte};
                    end else begin
                        n_len = {r_len[23:0], i_byte};
                    end
                    n_hdr_cnt = cnt_inc;
                    too_long  = (n_len > {16'd0, i_max_body}) || ({1'b0, n_len} > CAP);
                    if (cnt_inc == dlfd_pkg::HEADER_BYTES) begin
                        n_hdr_cnt  = '0;
                        o_item_vld = 1'b1;
                        if (too_long) begin
                            o_item.kind   = dlfd_pkg::KIND_END;
                            o_item.last   = 1'b1;
                            o_item.status = dlfd_pkg::ST_TOO_LONG;
                        end else begin
                            n_body_left = n_len[CNT_W-1:0];
                            n_phase     = (n_len[CNT_W-1:0] != '0)
                                          ? dlfd_pkg::PH_BODY : dlfd_pkg::PH_TRAILER;
                        end
                    end
                end
            endcase
        end

        o_item.frame_type  = n_type;
        o_item.source_addr = n_addr;
        o_item.body_length = (|n_len[31:16]) ? 16'hFFFF : n_len[15:0];
    end

    `DLFD_ASSERT_IMPL(a_body_left_nz, r_phase == dlfd_pkg::PH_BODY, r_body_left != '0, "body phase with no bytes left")
    `DLFD_ASSERT(a_hdr_cnt_range, r_hdr_cnt < dlfd_pkg::HEADER_BYTES, "header count out of range")
    `DLFD_ASSERT_NEXT(a_trailer_restart, i_take && r_phase == dlfd_pkg::PH_TRAILER, r_phase == dlfd_pkg::PH_HEADER && r_hdr_cnt == '0, "no header restart after trailer")

endmodule

`default_nettype wire

/* rtl/delimited_length_frame_deframer.sv */
// top level: byte stream in, header, body and end beats out
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Splits a byte stream into frames of an 11-byte header ('$', big-endian
// 16-bit type, 32-bit source address, 32-bit body length), the body and a
// '#' trailer. Each input beat is one byte and gives at most one output beat:
// a header beat on the eleventh header byte, one beat per body byte, and an
// end beat with status ok, delimiter error or too long (length above max_body
// or above a LEN_BITS counter, which skips the body and trailer). Body beats
// are tentative; drop them if the end status is not ok. The block takes one
// byte per cycle: the parser state updates in the accepting cycle and the
// result lands in a single output register, so a byte is accepted whenever
// that register is empty or being taken, and results appear in the cycle
// after their byte. max_body may only be written while the block is idle.
module delimited_length_frame_deframer #(
    parameter int LEN_BITS = dlfd_pkg::LEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_item_kind,
    output logic [15:0]      o_frame_type,
    output logic [31:0]      o_source_addr,
    output logic [15:0]      o_body_length,
    output logic [7:0]       o_body_byte,
    output logic             o_last,
    output logic [1:0]       o_status
);

    logic               r_out_vld;
    dlfd_pkg::t_item    r_out;
    logic [15:0]        r_max_body;

    logic               take;
    logic               item_vld;
    dlfd_pkg::t_item    item;

    assign o_ready = !r_out_vld || i_ready;
    assign take    = i_valid && o_ready;

    dlfd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_in_byte),
        .i_max_body (r_max_body),
        .o_item_vld (item_vld),
        .o_item     (item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= dlfd_pkg::MAX_BODY_RST;
        end else if (i_cfg_we) begin
            r_max_body <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= item_vld;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && item_vld) begin
            r_out <= item;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_item_kind   = r_out.kind;
    assign o_frame_type  = r_out.frame_type;
    assign o_source_addr = r_out.source_addr;
    assign o_body_length = r_out.body_length;
    assign o_body_byte   = r_out.body_byte;
    assign o_last        = r_out.last;
    assign o_status      = r_out.status;

    `DLFD_ASSERT_IMPL(a_last_on_end, o_valid, o_last == (o_item_kind == dlfd_pkg::KIND_END), "last flag does not match end beat")
    `DLFD_ASSERT_IMPL(a_status_on_end, o_valid && o_item_kind != dlfd_pkg::KIND_END, o_status == dlfd_pkg::ST_OK, "status set on non-end beat")
    `DLFD_ASSERT_IMPL(a_byte_on_body, o_valid && o_item_kind != dlfd_pkg::KIND_BODY, o_body_byte == '0, "body byte set on non-body beat")

endmodule

`default_nettype wire

/* sim/delimited_length_frame_deframer_test.sv */
// self-checking testbench for the delimited length frame deframer
`timescale 1ns / 1ps

module delimited_length_frame_deframer_test;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_BYTES = 350;
    localparam int          SETTLE      = 8;
    localparam logic [31:0] LEN_CAP     = 32'((64'd1 << dlfd_pkg::LEN_BITS_DEF) - 64'd1);

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'h0000;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_item_kind;
    logic [15:0] o_frame_type;
    logic [31:0] o_source_addr;
    logic [15:0] o_body_length;
    logic [7:0]  o_body_byte;
    logic        o_last;
    logic [1:0]  o_status;

    delimited_length_frame_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_item_kind   (o_item_kind),
        .o_frame_type  (o_frame_type),
        .o_source_addr (o_source_addr),
        .o_body_length (o_body_length),
        .o_body_byte   (o_body_byte),
        .o_last        (o_last),
        .o_status      (o_status)
    );

    // stimulus side
    logic [7:0]  wire_bytes[$];
    int          bytes_queued  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_left    = 0;
    logic [15:0] max_setting   = dlfd_pkg::MAX_BODY_RST;

    // predicted deframer state
    dlfd_pkg::t_item  due_beats[$];
    dlfd_pkg::t_phase rx_phase   = dlfd_pkg::PH_HEADER;
    logic [3:0]       hdr_count  = 4'd0;
    logic             start_seen = 1'b0;
    logic [15:0]      hdr_type   = 16'h0000;
    logic [31:0]      hdr_addr   = 32'h0000_0000;
    logic [31:0]      hdr_len    = 32'h0000_0000;
    logic [15:0]      body_left  = 16'h0000;
    logic [15:0]      max_copy   = dlfd_pkg::MAX_BODY_RST;

    // run bookkeeping
    int beats_in    = 0;
    int beats_out   = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    int n_headers   = 0;
    int n_body      = 0;
    int n_ok        = 0;
    int n_delim     = 0;
    int n_long      = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats still due", $time, due_beats.size());
            $display("delimited_length_frame_deframer: mismatch");
            $finish;
        end
    end

    function automatic dlfd_pkg::t_item frame_beat(dlfd_pkg::t_kind k, logic [7:0] b,
                                                   logic lst, dlfd_pkg::t_status st);
        dlfd_pkg::t_item it;
        it.kind        = k;
        it.frame_type  = hdr_type;
        it.source_addr = hdr_addr;
        it.body_length = (hdr_len > 32'h0000_FFFF) ? 16'hFFFF : hdr_len[15:0];
        it.body_byte   = b;
        it.last        = lst;
        it.status      = st;
        return it;
    endfunction

    task automatic add_beat(input dlfd_pkg::t_item it);
        due_beats.insert(due_beats.size(), it);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (rx_phase)
            dlfd_pkg::PH_BODY: begin
                add_beat(frame_beat(dlfd_pkg::KIND_BODY, b, 1'b0, dlfd_pkg::ST_OK));
                body_left = body_left - 16'd1;
                if (body_left == 16'd0) rx_phase = dlfd_pkg::PH_TRAILER;
            end
            dlfd_pkg::PH_TRAILER: begin
                add_beat(frame_beat(dlfd_pkg::KIND_END, 8'h00, 1'b1,
                    (start_seen && b == dlfd_pkg::END_MARK)
                    ? dlfd_pkg::ST_OK : dlfd_pkg::ST_DELIM));
                rx_phase  = dlfd_pkg::PH_HEADER;
                hdr_count = 4'd0;
            end
            default: begin
                rx_phase = dlfd_pkg::PH_HEADER;
                if (hdr_count >= dlfd_pkg::HEADER_BYTES) hdr_count = 4'd0;
                if (hdr_count == 4'd0) begin
                    start_seen = (b == dlfd_pkg::START_MARK);
                    hdr_type   = 16'h0000;
                    hdr_addr   = 32'h0000_0000;
                    hdr_len    = 32'h0000_0000;
                end else if (hdr_count < dlfd_pkg::TYPE_END) begin
                    hdr_type = {hdr_type[7:0], b};
                end else if (hdr_count < dlfd_pkg::LEN_OFFSET) begin
                    hdr_addr = {hdr_addr[23:0], b};
                end else begin
                    hdr_len = {hdr_len[23:0], b};
                end
                hdr_count = hdr_count + 4'd1;
                if (hdr_count == dlfd_pkg::HEADER_BYTES) begin
                    hdr_count = 4'd0;
                    if (hdr_len > {16'h0000, max_copy} || hdr_len > LEN_CAP) begin
                        add_beat(frame_beat(dlfd_pkg::KIND_END, 8'h00, 1'b1,
                                            dlfd_pkg::ST_TOO_LONG));
                    end else begin
                        add_beat(frame_beat(dlfd_pkg::KIND_HEADER, 8'h00, 1'b0,
                                            dlfd_pkg::ST_OK));
                        body_left = hdr_len[15:0];
                        rx_phase  = (body_left != 16'd0)
                                    ? dlfd_pkg::PH_BODY : dlfd_pkg::PH_TRAILER;
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: beat %0d %s expected %h actual %h",
                         $time, beats_out, name, want_v, got_v);
        end
    endtask

    task automatic check_beat();
        dlfd_pkg::t_item want;
        if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: beat %0d expected none actual kind %0d",
                         $time, beats_out, o_item_kind);
        end else begin
            want = due_beats.pop_front();
            compare_field("item_kind", 32'(want.kind), 32'(o_item_kind));
            compare_field("frame_type", 32'(want.frame_type), 32'(o_frame_type));
            compare_field("source_addr", want.source_addr, o_source_addr);
            compare_field("body_length", 32'(want.body_length), 32'(o_body_length));
            compare_field("body_byte", 32'(want.body_byte), 32'(o_body_byte));
            compare_field("last", 32'(want.last), 32'(o_last));
            compare_field("status", 32'(want.status), 32'(o_status));
            case (want.kind)
                dlfd_pkg::KIND_HEADER: n_headers++;
                dlfd_pkg::KIND_BODY:   n_body++;
                default: begin
                    if (want.status == dlfd_pkg::ST_OK) n_ok++;
                    else if (want.status == dlfd_pkg::ST_DELIM) n_delim++;
                    else n_long++;
                end
            endcase
        end
        beats_out++;
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid   <= 1'b1;
                i_in_byte <= wire_bytes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver hold-off countdown
    always @(posedge i_clk) begin
        if (stall_left != 0) stall_left <= stall_left - 1;
    end

    // monitor: check the output beat, then predict from the input beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_beat();
            if (i_cfg_we) max_copy = i_cfg_wdata;
            if (i_valid && o_ready) begin
                deframe_byte(i_in_byte);
                beats_in++;
            end
            i_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        wire_bytes.insert(wire_bytes.size(), b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] start_b, input logic [15:0] ftype,
                               input logic [31:0] faddr, input logic [31:0] flen,
                               input logic [7:0] trail);
        push_byte(start_b);
        for (int i = 1; i >= 0; i--) push_byte(ftype[8*i +: 8]);
        for (int i = 3; i >= 0; i--) push_byte(faddr[8*i +: 8]);
        for (int i = 3; i >= 0; i--) push_byte(flen[8*i +: 8]);
        if (flen <= {16'h0000, max_setting}) begin
            for (int i = 0; i < int'(flen); i++) push_byte(8'($urandom_range(255)));
            push_byte(trail);
        end
    endtask

    task automatic random_frame();
        logic [7:0]  start_b;
        logic [7:0]  trail;
        logic [31:0] flen;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // loose bytes that still fill one header slot
            repeat (11) push_byte(8'($urandom_range(255)));
        end else begin
            start_b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : dlfd_pkg::START_MARK;
            trail   = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                               : dlfd_pkg::END_MARK;
            case ($urandom_range(9))
                0: flen = 32'd0;
                1: flen = (max_setting <= 16'd300) ? {16'h0000, max_setting}
                                                   : 32'($urandom_range(256, 300));
                2: flen = {16'h0000, max_setting} + 32'd1;
                3: flen = $urandom;
                default: flen = $urandom_range(0, (max_setting < 16'd24)
                                                  ? 32'(max_setting) : 32'd24);
            endcase
            queue_frame(start_b, 16'($urandom), $urandom, flen, trail);
        end
    endtask

    task automatic wait_drained();
        while (beats_in != bytes_queued || due_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_max_body(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        max_setting = v;
    endtask

    initial begin
        int target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 18;
        recv_idle_pct = 54;

        // good frame with all-ones type and address fields and a one-byte body
        queue_frame(dlfd_pkg::START_MARK, 16'hFFFF, 32'hFFFF_FFFF, 32'd1,
                    dlfd_pkg::END_MARK);
        // bad start and a length past the counter width: too long wins
        queue_frame(8'h00, 16'h0000, 32'h0000_0000, 32'h0001_0000, dlfd_pkg::END_MARK);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 54;
                recv_idle_pct = 18;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: write_max_body(16'h0000);
                    2: write_max_body(16'($urandom_range(1, 40)));
                    3: write_max_body(16'($urandom_range(41, 65534)));
                    default: write_max_body(16'hFFFF);
                endcase
            end
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) random_frame();
            if (ph == 0) begin
                // long receiver stall while bytes keep coming
                while (beats_in < 100) @(posedge i_clk);
                stall_left <= 400;
            end
        end

        wait_drained();
        $display("run covered %0d bytes in, %0d beats out over five max_body settings",
                 beats_in, beats_out);
        $display("headers %0d, body %0d, ends ok %0d, delimiter errors %0d, too long %0d",
                 n_headers, n_body, n_ok, n_delim, n_long);
        if (mismatches == 0) begin
            $display("delimited_length_frame_deframer: match");
        end else begin
            $display("delimited_length_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule
